// ===== design/ort_pkg.sv =====
package ort_pkg;

    localparam int COORD_BITS    = 24;
    localparam int DIR_FRAC_BITS = 14;
    localparam int DIR_BITS      = DIR_FRAC_BITS + 2;
    localparam int SIZE_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);

    localparam logic [SIZE_BITS-1:0] FIRST_HALF_WIDTH_RST  = 16'd230;
    localparam logic [SIZE_BITS-1:0] FIRST_LENGTH_RST      = 16'd1101;
    localparam logic [SIZE_BITS-1:0] SECOND_HALF_WIDTH_RST = 16'd83;
    localparam logic [SIZE_BITS-1:0] SECOND_LENGTH_RST     = 16'd410;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIRST_HALF_WIDTH  = 2'd0,
        CFG_FIRST_LENGTH      = 2'd1,
        CFG_SECOND_HALF_WIDTH = 2'd2,
        CFG_SECOND_LENGTH     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        AXIS_D1   = 3'd0,
        AXIS_N1   = 3'd1,
        AXIS_N2   = 3'd2,
        AXIS_D2   = 3'd3,
        AXIS_NONE = 3'd4
    } t_axis;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_pos_x;
        logic signed [COORD_BITS-1:0] first_pos_y;
        logic signed [DIR_BITS-1:0]   first_dir_x;
        logic signed [DIR_BITS-1:0]   first_dir_y;
        logic signed [COORD_BITS-1:0] second_pos_x;
        logic signed [COORD_BITS-1:0] second_pos_y;
        logic signed [DIR_BITS-1:0]   second_dir_x;
        logic signed [DIR_BITS-1:0]   second_dir_y;
    } t_in;

    typedef struct packed {
        logic       collide;
        logic [2:0] separating_axis;
    } t_out;

    // relative position and headings, as queued between front and back
    typedef struct packed {
        logic signed [COORD_BITS:0]   dpx;
        logic signed [COORD_BITS:0]   dpy;
        logic signed [DIR_BITS-1:0]   ax;
        logic signed [DIR_BITS-1:0]   ay;
        logic signed [DIR_BITS-1:0]   bx;
        logic signed [DIR_BITS-1:0]   by;
    } t_job;

    typedef struct packed {
        logic [SIZE_BITS-1:0] hw_a;
        logic [SIZE_BITS-1:0] len_a;
        logic [SIZE_BITS-1:0] hw_b;
        logic [SIZE_BITS-1:0] len_b;
    } t_cfg;

endpackage

// ===== design/ort_front.sv =====
module ort_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ort_pkg::t_in  i_item,
    output logic          o_stall,
    output logic          o_head_valid,
    output ort_pkg::t_job o_head,
    input  logic          i_pop
);
    import ort_pkg::*;

    t_job             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;
    logic             push, pop;
    t_job             job;

    assign o_stall      = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && o_head_valid;

    always_comb begin
        job.dpx = (COORD_BITS+1)'(i_item.first_pos_x) - (COORD_BITS+1)'(i_item.second_pos_x);
        job.dpy = (COORD_BITS+1)'(i_item.first_pos_y) - (COORD_BITS+1)'(i_item.second_pos_y);
        job.ax  = i_item.first_dir_x;
        job.ay  = i_item.first_dir_y;
        job.bx  = i_item.second_dir_x;
        job.by  = i_item.second_dir_y;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (QAW+1)'(QDEPTH)) |-> !push)
        else $error("queue overrun");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count slip");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !pop)
        else $error("queue underrun");

endmodule

// ===== design/ort_back.sv =====
module ort_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ort_pkg::t_cfg i_cfg,
    input  logic          i_head_valid,
    input  ort_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_valid,
    output ort_pkg::t_out o_item,
    input  logic          i_stall
);
    import ort_pkg::*;

    localparam int PPW = COORD_BITS + 1 + DIR_BITS;
    localparam int DCW = PPW + 1;
    localparam int DPW = 2 * DIR_BITS;
    localparam int SW  = DPW + 1;
    localparam int MW  = SIZE_BITS + 1 + SW;
    localparam int CW  = ((DCW + DIR_FRAC_BITS > MW) ? DCW + DIR_FRAC_BITS : MW) + 3;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1
    logic signed [PPW-1:0] r_px [4];
    logic signed [PPW-1:0] r_py [4];
    logic signed [DPW-1:0] r_axx, r_ayy, r_bxx, r_byy, r_axbx, r_ayby, r_axby, r_aybx;
    // stage 2
    logic signed [DCW-1:0] r_dc2 [4];
    logic signed [SW-1:0]  r_sa, r_sb, r_d, r_x;
    // stage 3
    logic signed [DCW-1:0] r_dc3 [4];
    logic signed [MW-1:0]  r_len_a_sa, r_hw_a_sa, r_hw_b_ax, r_hw_a_ax, r_len_b_d, r_len_a_d;
    logic signed [MW-1:0]  r_hw_b_ad, r_hw_a_ad, r_len_b_x, r_len_a_x, r_hw_b_sb, r_len_b_sb;
    // output
    t_out                  r_out;

    logic signed [SW-1:0]  abs_d, abs_x;
    logic signed [SIZE_BITS:0] hw_a, len_a, hw_b, len_b;
    logic signed [CW-1:0]  wa [4];
    logic signed [CW-1:0]  la [4];
    logic signed [CW-1:0]  wb [4];
    logic signed [CW-1:0]  lb [4];
    logic signed [CW-1:0]  dc, up1, up2;
    logic [3:0]            ok;
    t_out                  res;

    assign en      = !(r_v4 && i_stall);
    assign o_pop   = en && i_head_valid;
    assign o_valid = r_v4;
    assign o_item  = r_out;

    assign hw_a  = {1'b0, i_cfg.hw_a};
    assign len_a = {1'b0, i_cfg.len_a};
    assign hw_b  = {1'b0, i_cfg.hw_b};
    assign len_b = {1'b0, i_cfg.len_b};
    assign abs_d = r_d[SW-1] ? -r_d : r_d;
    assign abs_x = r_x[SW-1] ? -r_x : r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_head_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // centre offsets on each axis; negative y parts are subtracted later
            r_px[0] <= i_head.dpx * i_head.ax;
            r_py[0] <= i_head.dpy * i_head.ay;
            r_px[1] <= i_head.dpx * i_head.ay;
            r_py[1] <= i_head.dpy * i_head.ax;
            r_px[2] <= i_head.dpx * i_head.by;
            r_py[2] <= i_head.dpy * i_head.bx;
            r_px[3] <= i_head.dpx * i_head.bx;
            r_py[3] <= i_head.dpy * i_head.by;
            r_axx   <= i_head.ax * i_head.ax;
            r_ayy   <= i_head.ay * i_head.ay;
            r_bxx   <= i_head.bx * i_head.bx;
            r_byy   <= i_head.by * i_head.by;
            r_axbx  <= i_head.ax * i_head.bx;
            r_ayby  <= i_head.ay * i_head.by;
            r_axby  <= i_head.ax * i_head.by;
            r_aybx  <= i_head.ay * i_head.bx;

            r_dc2[0] <= DCW'(r_px[0]) + DCW'(r_py[0]);
            r_dc2[1] <= DCW'(r_px[1]) - DCW'(r_py[1]);
            r_dc2[2] <= DCW'(r_px[2]) - DCW'(r_py[2]);
            r_dc2[3] <= DCW'(r_px[3]) + DCW'(r_py[3]);
            r_sa     <= SW'(r_axx) + SW'(r_ayy);
            r_sb     <= SW'(r_bxx) + SW'(r_byy);
            r_d      <= SW'(r_axbx) + SW'(r_ayby);
            r_x      <= SW'(r_axby) - SW'(r_aybx);

            r_dc3      <= r_dc2;
            r_len_a_sa <= len_a * r_sa;
            r_hw_a_sa  <= hw_a * r_sa;
            r_hw_b_ax  <= hw_b * abs_x;
            r_hw_a_ax  <= hw_a * abs_x;
            r_len_b_d  <= len_b * r_d;
            r_len_a_d  <= len_a * r_d;
            r_hw_b_ad  <= hw_b * abs_d;
            r_hw_a_ad  <= hw_a * abs_d;
            r_len_b_x  <= len_b * r_x;
            r_len_a_x  <= len_a * r_x;
            r_hw_b_sb  <= hw_b * r_sb;
            r_len_b_sb <= len_b * r_sb;

            r_out <= res;
        end
    end

    always_comb begin
        wa[0] = '0;               la[0] = CW'(r_len_a_sa);
        wb[0] = CW'(r_hw_b_ax);   lb[0] = CW'(r_len_b_d);
        wa[1] = CW'(r_hw_a_sa);   la[1] = '0;
        wb[1] = CW'(r_hw_b_ad);   lb[1] = -CW'(r_len_b_x);
        wa[2] = CW'(r_hw_a_ad);   la[2] = CW'(r_len_a_x);
        wb[2] = CW'(r_hw_b_sb);   lb[2] = '0;
        wa[3] = CW'(r_hw_a_ax);   la[3] = CW'(r_len_a_d);
        wb[3] = '0;               lb[3] = CW'(r_len_b_sb);
        for (int k = 0; k < 4; k++) begin
            dc  = CW'(r_dc3[k]) <<< DIR_FRAC_BITS;
            up1 = wa[k] + wb[k] + (lb[k][CW-1] ? CW'(0) : lb[k]) - (la[k][CW-1] ? la[k] : CW'(0));
            up2 = wa[k] + wb[k] + (la[k][CW-1] ? CW'(0) : la[k]) - (lb[k][CW-1] ? lb[k] : CW'(0));
            ok[k] = (dc <= up1) && (-dc <= up2);
        end
        res.separating_axis = AXIS_NONE;
        for (int k = 3; k >= 0; k--) begin
            if (!ok[k]) begin
                res.separating_axis = 3'(k);
            end
        end
        res.collide = (ok == 4'hF);
    end

endmodule

// ===== design/oriented_rectangle_overlap_test.sv =====
// oriented rectangle overlap test, one vehicle pair per item
// input channel: i_valid / o_stall carry an item with both reference points
// and heading vectors; an item is taken at a clock edge with i_valid high and
// o_stall low
// output channel: o_valid / i_stall carry collide and the first separating axis
// (0 d1, 1 n1, 2 n2, 3 d2, 4 none); taken when o_valid high and i_stall low
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 first half width, 1 first length, 2 second half width, 3 second length);
// the user must write only while no item is in flight; the block does not enforce it
// path: the accept edge writes the queue, then three arithmetic stages and the
// output register lead to o_valid; throughput one item per cycle while i_stall
// is low, set by the fully pipelined back end
// a four-entry queue parts the front from the back; while i_stall holds with
// o_valid high, the back end freezes, the queue fills and o_stall rises once it is full
// reset (synchronous, active low) empties the queue and the pipeline and loads
// the default sizes
module oriented_rectangle_overlap_test (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  ort_pkg::t_in                   i_item,
    output logic                           o_valid,
    input  logic                           i_stall,
    output ort_pkg::t_out                  o_item,
    input  logic                           i_cfg_we,
    input  logic [ort_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [ort_pkg::SIZE_BITS-1:0]  i_cfg_data
);
    import ort_pkg::*;

    t_cfg r_cfg;
    logic head_valid, pop;
    t_job head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hw_a  <= FIRST_HALF_WIDTH_RST;
            r_cfg.len_a <= FIRST_LENGTH_RST;
            r_cfg.hw_b  <= SECOND_HALF_WIDTH_RST;
            r_cfg.len_b <= SECOND_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIRST_HALF_WIDTH:  r_cfg.hw_a  <= i_cfg_data;
                CFG_FIRST_LENGTH:      r_cfg.len_a <= i_cfg_data;
                CFG_SECOND_HALF_WIDTH: r_cfg.hw_b  <= i_cfg_data;
                CFG_SECOND_LENGTH:     r_cfg.len_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ort_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (i_item),
        .o_stall      (o_stall),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    ort_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_item       (o_item),
        .i_stall      (i_stall)
    );

    a_collide_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.collide == (o_item.separating_axis == AXIS_NONE)))
        else $error("collide and axis disagree");
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.separating_axis <= AXIS_NONE))
        else $error("axis out of range");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_valid && !o_stall))
        else $error("state left after reset");

endmodule
